// ===== hdl/touch_report_decoder_defines.svh =====
// Assertion macros shared by the decoder RTL.
`ifndef TOUCH_REPORT_DECODER_DEFINES_SVH
`define TOUCH_REPORT_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define TRD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define TRD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/trd_pkg.sv =====
package trd_pkg;

	localparam int POINTS     = 2;
	localparam int SLOT_W     = 1;
	localparam int HDR_LEN    = 3;
	localparam int REC_LEN    = 6;
	localparam int REPORT_LEN = HDR_LEN + REC_LEN * POINTS;
	localparam int POS_W      = 5;
	localparam int REC_K_W    = 3;
	localparam int COORD_W    = 12;
	localparam int RES_W      = 13;
	localparam int CNT_W      = 3;
	localparam int REC_KEPT   = 4;

	localparam logic [POS_W-1:0]   COUNT_POS  = POS_W'(2);
	localparam logic [POS_W-1:0]   FIRST_REC  = POS_W'(HDR_LEN);
	localparam logic [POS_W-1:0]   LAST_POS   = POS_W'(REPORT_LEN - 1);
	localparam logic [REC_K_W-1:0] REC_LAST_K = REC_K_W'(REC_LEN - 1);
	localparam logic [REC_K_W-1:0] REC_KEPT_K = REC_K_W'(REC_KEPT);
	localparam logic [CNT_W-1:0]   MAX_COUNT  = CNT_W'(POINTS);
	localparam logic [RES_W-1:0]   RES_RESET  = 13'h1000;
	localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(POINTS - 1);

	// Register indexes on the configuration port.
	typedef enum logic [0:0] {
		REG_RES_X = 1'b0,
		REG_RES_Y = 1'b1
	} reg_idx_t;

	// First four bytes of a point record; the last two carry nothing used.
	typedef struct packed {
		logic [7:0] b3;
		logic [7:0] b2;
		logic [7:0] b1;
		logic [7:0] b0;
	} rec_t;

	// Verdict on one completed record.
	typedef struct packed {
		logic               take;
		logic [SLOT_W-1:0]  slot;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} judge_t;

endpackage

// ===== hdl/trd_judge.sv =====
module trd_judge
	import trd_pkg::*;
(
	input  rec_t             rec,
	input  logic [CNT_W-1:0] point_count,
	input  logic [RES_W-1:0] res_x,
	input  logic [RES_W-1:0] res_y,
	output judge_t           verdict
);

	logic [3:0]         slot_raw;
	logic [COORD_W-1:0] x;
	logic [COORD_W-1:0] y;
	logic               lifted;
	logic               slot_ok;
	logic               x_ok;
	logic               y_ok;

	assign slot_raw = rec.b2[7:4];
	assign x        = {rec.b0[3:0], rec.b1};
	assign y        = {rec.b2[3:0], rec.b3};
	assign lifted   = rec.b0[6];
	assign slot_ok  = slot_raw < 4'(POINTS);
	assign x_ok     = {1'b0, x} < res_x;
	assign y_ok     = {1'b0, y} < res_y;

	// Drop empty reports, lifted records, foreign slots and off-panel points.
	always_comb begin
		verdict.take = (point_count != '0) && !lifted && slot_ok && x_ok && y_ok;
		verdict.slot = slot_raw[SLOT_W-1:0];
		verdict.x    = x;
		verdict.y    = y;
	end

endmodule

// ===== hdl/touch_report_decoder.sv =====
// Results appear the cycle after the last report byte is accepted, then one per cycle while out_stall is low.
// Throughput: one byte per cycle while in_stall is low; a report of 15 bytes yields 2 slot results.
// The only input stall is on a last byte while the previous report's results are still held.
// Reset (arst_n low, asynchronous): byte position, count, error flag, slot latches and
// output valid clear; res_x and res_y return to 4096. Record bytes are not reset.
`include "touch_report_decoder_defines.svh"

module touch_report_decoder
	import trd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// byte input
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               read_error,
	// slot results
	output logic               out_valid,
	input  logic               out_stall,
	output logic [SLOT_W-1:0]  slot_index,
	output logic               contact,
	output logic [COORD_W-1:0] pos_x,
	output logic [COORD_W-1:0] pos_y,
	output logic               any_touch,
	output logic               report_invalid,
	output logic               last,
	// configuration writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [0:0]         cfg_index,
	input  logic [RES_W-1:0]   cfg_data
);

	// Configuration registers.
	logic [RES_W-1:0] res_x_q;
	logic [RES_W-1:0] res_y_q;

	// Report parsing state.
	logic [POS_W-1:0]   pos_q;
	logic [REC_K_W-1:0] rec_k_q;
	logic [CNT_W-1:0]   count_q;
	logic               err_q;
	logic [7:0]         rec_b_q [REC_KEPT];

	// Per-slot latches, built up as records complete.
	logic               slot_on_q [POINTS];
	logic [COORD_W-1:0] slot_x_q  [POINTS];
	logic [COORD_W-1:0] slot_y_q  [POINTS];
	logic               slot_on_n [POINTS];
	logic [COORD_W-1:0] slot_x_n  [POINTS];
	logic [COORD_W-1:0] slot_y_n  [POINTS];

	// Result buffer: a full report's worth, drained one slot per transfer.
	logic               out_valid_q;
	logic [SLOT_W-1:0]  out_idx_q;
	logic               res_on_q [POINTS];
	logic [COORD_W-1:0] res_x_o_q [POINTS];
	logic [COORD_W-1:0] res_y_o_q [POINTS];
	logic               any_q;
	logic               inv_q;

	logic   in_xfer;
	logic   out_xfer;
	logic   in_record;
	logic   rec_done;
	logic   rpt_done;
	logic   invalid_n;
	logic   any_n;
	rec_t   rec;
	judge_t verdict;

	assign cfg_ready = 1'b1;

	// Hold a last byte back only while the previous report still sits in the buffer.
	assign in_stall  = out_valid_q && (pos_q == LAST_POS);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign in_record = pos_q >= FIRST_REC;
	assign rec_done  = in_record && (rec_k_q == REC_LAST_K);
	assign rpt_done  = pos_q == LAST_POS;

	// Config writes must land only while idle; the user keeps to that, the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_x_q <= RES_RESET;
			res_y_q <= RES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (reg_idx_t'(cfg_index))
				REG_RES_X: res_x_q <= cfg_data;
				REG_RES_Y: res_y_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// Record bytes 0..3 as stored; byte 4 and 5 are only counted.
	assign rec.b0 = rec_b_q[0];
	assign rec.b1 = rec_b_q[1];
	assign rec.b2 = rec_b_q[2];
	assign rec.b3 = rec_b_q[3];

	trd_judge u_judge (
		.rec         (rec),
		.point_count (count_q),
		.res_x       (res_x_q),
		.res_y       (res_y_q),
		.verdict     (verdict)
	);

	// Apply the verdict when a record's final byte is accepted; later records overwrite.
	always_comb begin
		for (int i = 0; i < POINTS; i++) begin
			slot_on_n[i] = slot_on_q[i];
			slot_x_n[i]  = slot_x_q[i];
			slot_y_n[i]  = slot_y_q[i];
			if (rec_done && verdict.take && (verdict.slot == SLOT_W'(i))) begin
				slot_on_n[i] = 1'b1;
				slot_x_n[i]  = verdict.x;
				slot_y_n[i]  = verdict.y;
			end
		end
	end

	// Report verdict, counting the error flag of the last byte itself.
	always_comb begin
		invalid_n = err_q || read_error || (count_q > MAX_COUNT);
		any_n     = 1'b0;
		for (int i = 0; i < POINTS; i++) begin
			any_n = any_n || slot_on_n[i];
		end
		any_n = any_n && !invalid_n;
	end

	// Parse state: advance per accepted byte, clear after the last one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			rec_k_q <= '0;
			count_q <= '0;
			err_q   <= 1'b0;
			for (int i = 0; i < POINTS; i++) begin
				slot_on_q[i] <= 1'b0;
				slot_x_q[i]  <= '0;
				slot_y_q[i]  <= '0;
			end
		end else if (in_xfer) begin
			if (rpt_done) begin
				pos_q   <= '0;
				rec_k_q <= '0;
				count_q <= '0;
				err_q   <= 1'b0;
				for (int i = 0; i < POINTS; i++) begin
					slot_on_q[i] <= 1'b0;
					slot_x_q[i]  <= '0;
					slot_y_q[i]  <= '0;
				end
			end else begin
				pos_q <= pos_q + POS_W'(1);
				err_q <= err_q || read_error;
				if (pos_q == COUNT_POS) begin
					count_q <= data_byte[CNT_W-1:0];
				end
				if (in_record) begin
					rec_k_q <= rec_done ? '0 : rec_k_q + REC_K_W'(1);
				end
				for (int i = 0; i < POINTS; i++) begin
					slot_on_q[i] <= slot_on_n[i];
					slot_x_q[i]  <= slot_x_n[i];
					slot_y_q[i]  <= slot_y_n[i];
				end
			end
		end
	end

	// Capture record payload bytes; no reset, each is written before it is judged.
	always_ff @(posedge clk) begin
		if (in_xfer && in_record && (rec_k_q < REC_KEPT_K)) begin
			rec_b_q[rec_k_q[1:0]] <= data_byte;
		end
	end

	// Result buffer control: load on the last byte, drain one slot per transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
		end else if (in_xfer && rpt_done) begin
			out_valid_q <= 1'b1;
			out_idx_q   <= '0;
		end else if (out_xfer) begin
			if (out_idx_q == LAST_SLOT) begin
				out_valid_q <= 1'b0;
			end
			out_idx_q <= out_idx_q + SLOT_W'(1);
		end
	end

	// Result payload; a released or invalid slot reads as zero position.
	always_ff @(posedge clk) begin
		if (in_xfer && rpt_done) begin
			any_q <= any_n;
			inv_q <= invalid_n;
			for (int i = 0; i < POINTS; i++) begin
				res_on_q[i]  <= slot_on_n[i] && !invalid_n;
				res_x_o_q[i] <= (slot_on_n[i] && !invalid_n) ? slot_x_n[i] : '0;
				res_y_o_q[i] <= (slot_on_n[i] && !invalid_n) ? slot_y_n[i] : '0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign slot_index     = out_idx_q;
	assign contact        = res_on_q[out_idx_q];
	assign pos_x          = res_x_o_q[out_idx_q];
	assign pos_y          = res_y_o_q[out_idx_q];
	assign any_touch      = any_q;
	assign report_invalid = inv_q;
	assign last           = out_idx_q == LAST_SLOT;

	`TRD_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= LAST_POS, "byte position past report end")
	`TRD_ASSERT_NOW(a_hdr_k_zero, !in_record, rec_k_q == '0, "record offset moved in header")
	`TRD_ASSERT_NEXT(a_load_first, in_xfer && rpt_done, out_valid && (slot_index == '0),
		"report end did not present the first slot")
	`TRD_ASSERT_NOW(a_invalid_clear, out_valid && report_invalid,
		!contact && !any_touch && (pos_x == '0) && (pos_y == '0),
		"invalid report shows a contact")
	`TRD_ASSERT_NOW(a_release_zero, out_valid && !contact, (pos_x == '0) && (pos_y == '0),
		"released slot carries a position")

endmodule
